[hdl/dddw_pkg.sv]
`timescale 1ns / 1ps

package dddw_pkg;

    // Opcodes of an input item
    localparam logic [1:0] OP_SET_VALUE = 2'd0;
    localparam logic [1:0] OP_END_FRAME = 2'd1;
    localparam logic [1:0] OP_INIT      = 2'd2;

    // Configuration register indexes
    localparam logic CFG_BRIGHTNESS = 1'b0;
    localparam logic CFG_SCAN_LIMIT = 1'b1;

    // Display controller register addresses
    localparam logic [3:0] ADDR_DECODE_MODE = 4'h9;
    localparam logic [3:0] ADDR_INTENSITY   = 4'hA;
    localparam logic [3:0] ADDR_SCAN_LIMIT  = 4'hB;
    localparam logic [3:0] ADDR_SHUTDOWN    = 4'hC;
    localparam logic [3:0] ADDR_DISP_TEST   = 4'hF;
    localparam logic [3:0] ADDR_DIGIT_BASE0 = 4'h1;
    localparam logic [3:0] ADDR_DIGIT_BASE1 = 4'h5;

    localparam logic [7:0] BRIGHTNESS_RST = 8'd0;
    localparam logic [7:0] SCAN_LIMIT_RST = 8'd7;

    localparam int INIT_LEN   = 14;
    localparam int DIGITS     = 4;
    localparam int TH_BITS    = 7;   // thousands quotient reaches 65
    localparam int DEC_BITS   = 4;
    localparam int CONV_STEPS = TH_BITS + 2 * DEC_BITS;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        channel;
        logic [15:0] value;
    } t_in;

    typedef struct packed {
        logic [3:0] reg_addr;
        logic [7:0] reg_data;
        logic       last;
    } t_out;

    // Status and digits from the converter
    typedef struct packed {
        logic                done;
        logic [TH_BITS-1:0]  thousands;
        logic [DEC_BITS-1:0] hundreds;
        logic [DEC_BITS-1:0] tens;
        logic [DEC_BITS-1:0] ones;
    } t_bcd_res;

    // Trial divisor for each step of the restoring division
    function automatic logic [15:0] f_divisor(input logic [3:0] step);
        logic [15:0] d;
        unique case (step)
            4'd0:    d = 16'd64000;
            4'd1:    d = 16'd32000;
            4'd2:    d = 16'd16000;
            4'd3:    d = 16'd8000;
            4'd4:    d = 16'd4000;
            4'd5:    d = 16'd2000;
            4'd6:    d = 16'd1000;
            4'd7:    d = 16'd800;
            4'd8:    d = 16'd400;
            4'd9:    d = 16'd200;
            4'd10:   d = 16'd100;
            4'd11:   d = 16'd80;
            4'd12:   d = 16'd40;
            4'd13:   d = 16'd20;
            4'd14:   d = 16'd10;
            default: d = 16'hFFFF;
        endcase
        return d;
    endfunction

    // Start-up write sequence, one entry per index
    function automatic t_out f_init_write(input logic [3:0] idx,
                                          input logic [7:0] bright,
                                          input logic [7:0] scan);
        t_out w;
        w.last = 1'b0;
        unique case (idx)
            4'd0:    begin w.reg_addr = ADDR_DECODE_MODE; w.reg_data = 8'hFF;  end
            4'd1:    begin w.reg_addr = ADDR_INTENSITY;   w.reg_data = bright; end
            4'd2:    begin w.reg_addr = ADDR_SCAN_LIMIT;  w.reg_data = scan;   end
            4'd3:    begin w.reg_addr = ADDR_SHUTDOWN;    w.reg_data = 8'h01;  end
            4'd4:    begin w.reg_addr = ADDR_DISP_TEST;   w.reg_data = 8'h0F;  end
            4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12: begin
                w.reg_addr = idx - 4'd4;
                w.reg_data = 8'h0F;
            end
            4'd13:   begin w.reg_addr = ADDR_DISP_TEST;   w.reg_data = 8'h08;  end
            default: begin w.reg_addr = ADDR_DISP_TEST;   w.reg_data = 8'h08;  end
        endcase
        return w;
    endfunction

endpackage

[hdl/decimal_digit_display_writer_core.sv]
`timescale 1ns / 1ps

// Channel  | Direction | Handshake               | Payload
// in       | input     | i_in_valid / o_in_stall  | i_in_data  (opcode, channel, value)
// out      | output    | o_out_valid / i_out_stall| o_out_data (reg_addr, reg_data, last)
// cfg      | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// Set value is taken without stalling the input. Each pending half of an end frame runs
// through the shared compare-subtract converter (start plus 15 quotient bits) and then
// gives four digit writes; a pending half 1 chains straight after half 0. Init gives the
// start-up write sequence. The input is stalled while a frame or init sequence is in
// progress. Reset is synchronous: nothing pending, brightness 0, scan limit 7.

module decimal_digit_display_writer_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  dddw_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output dddw_pkg::t_out   o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [7:0]       i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_DIGITS,
        S_INIT
    } t_state;

    localparam logic [3:0] INIT_END  = 4'(dddw_pkg::INIT_LEN - 1);
    localparam logic [3:0] DIGIT_END = 4'(dddw_pkg::DIGITS - 1);

    t_state          r_state, n_state;
    logic [3:0]      r_idx, n_idx;
    logic            r_half, n_half;
    logic [15:0]     r_h0_val, n_h0_val;
    logic [15:0]     r_h1_val, n_h1_val;
    logic            r_h0_pend, n_h0_pend;
    logic            r_h1_pend, n_h1_pend;
    logic [7:0]      r_bright, n_bright;
    logic [7:0]      r_scan, n_scan;
    logic            r_out_valid, n_out_valid;
    dddw_pkg::t_out  r_out, n_out;

    logic               w_slot;
    logic               w_start;
    logic [15:0]        w_start_value;
    dddw_pkg::t_bcd_res w_bcd;
    logic [7:0]         w_digit;
    logic [3:0]         w_base;

    dddw_bcd_unit u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_value (w_start_value),
        .o_res   (w_bcd)
    );

    assign w_slot = !r_out_valid || !i_out_stall;
    assign w_base = r_half ? dddw_pkg::ADDR_DIGIT_BASE1 : dddw_pkg::ADDR_DIGIT_BASE0;

    always_comb begin
        case (r_idx[1:0])
            2'd0:    w_digit = 8'(w_bcd.thousands);
            2'd1:    w_digit = 8'(w_bcd.hundreds);
            2'd2:    w_digit = 8'(w_bcd.tens);
            default: w_digit = 8'(w_bcd.ones);
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_half        = r_half;
        n_h0_val      = r_h0_val;
        n_h1_val      = r_h1_val;
        n_h0_pend     = r_h0_pend;
        n_h1_pend     = r_h1_pend;
        n_bright      = r_bright;
        n_scan        = r_scan;
        n_out_valid   = r_out_valid;
        n_out         = r_out;
        w_start       = 1'b0;
        w_start_value = r_h0_val;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dddw_pkg::CFG_BRIGHTNESS: n_bright = i_cfg_data;
                dddw_pkg::CFG_SCAN_LIMIT: n_scan   = i_cfg_data;
                default:                  n_scan   = r_scan;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_data.opcode)
                        dddw_pkg::OP_SET_VALUE: begin
                            if (i_in_data.channel) begin
                                n_h1_val  = i_in_data.value;
                                n_h1_pend = 1'b1;
                            end else begin
                                n_h0_val  = i_in_data.value;
                                n_h0_pend = 1'b1;
                            end
                        end
                        dddw_pkg::OP_END_FRAME: begin
                            if (r_h0_pend) begin
                                n_h0_pend     = 1'b0;
                                n_half        = 1'b0;
                                w_start       = 1'b1;
                                w_start_value = r_h0_val;
                                n_state       = S_CONV;
                            end else if (r_h1_pend) begin
                                n_h1_pend     = 1'b0;
                                n_half        = 1'b1;
                                w_start       = 1'b1;
                                w_start_value = r_h1_val;
                                n_state       = S_CONV;
                            end
                        end
                        dddw_pkg::OP_INIT: begin
                            n_idx   = '0;
                            n_state = S_INIT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CONV: begin
                if (w_bcd.done) begin
                    n_idx   = '0;
                    n_state = S_DIGITS;
                end
            end
            S_DIGITS: begin
                if (w_slot) begin
                    n_out_valid    = 1'b1;
                    n_out.reg_addr = w_base + r_idx;
                    n_out.reg_data = w_digit;
                    n_out.last     = 1'b0;
                    if (r_idx == DIGIT_END) begin
                        // chain straight into half 1 when it is pending too
                        if (!r_half && r_h1_pend) begin
                            n_h1_pend     = 1'b0;
                            n_half        = 1'b1;
                            w_start       = 1'b1;
                            w_start_value = r_h1_val;
                            n_state       = S_CONV;
                        end else begin
                            n_out.last = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            S_INIT: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out       = dddw_pkg::f_init_write(r_idx, r_bright, r_scan);
                    if (r_idx == INIT_END) begin
                        n_out.last = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_half      <= 1'b0;
            r_h0_val    <= '0;
            r_h1_val    <= '0;
            r_h0_pend   <= 1'b0;
            r_h1_pend   <= 1'b0;
            r_bright    <= dddw_pkg::BRIGHTNESS_RST;
            r_scan      <= dddw_pkg::SCAN_LIMIT_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_half      <= n_half;
            r_h0_val    <= n_h0_val;
            r_h1_val    <= n_h1_val;
            r_h0_pend   <= n_h0_pend;
            r_h1_pend   <= n_h1_pend;
            r_bright    <= n_bright;
            r_scan      <= n_scan;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Converter only finishes while the sequencer waits for it
    a_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bcd.done |-> r_state == S_CONV)
        else $error("converter done outside conversion");

    // Final init write carries last
    a_init_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT && r_idx == INIT_END && w_slot)
        |=> (o_out_valid && o_out_data.last && r_state == S_IDLE))
        else $error("init sequence did not end with last");

    // No write is loaded while a conversion runs
    a_no_write_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV && r_out_valid && !i_out_stall) |=> !r_out_valid)
        else $error("write produced during conversion");

    // Digit index stays within one half
    a_digit_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIGITS |-> r_idx <= DIGIT_END)
        else $error("digit index out of range");

endmodule

[hdl/dddw_bcd_unit.sv]
`timescale 1ns / 1ps

module dddw_bcd_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [15:0]         i_value,
    output dddw_pkg::t_bcd_res  o_res
);

    localparam logic [3:0] LAST_STEP = 4'(dddw_pkg::CONV_STEPS - 1);
    localparam logic [3:0] TH_END    = 4'(dddw_pkg::TH_BITS - 1);
    localparam logic [3:0] HU_END    = 4'(dddw_pkg::TH_BITS + dddw_pkg::DEC_BITS - 1);

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_step;
    logic [15:0] r_rem;
    logic [dddw_pkg::TH_BITS-1:0]  r_th;
    logic [dddw_pkg::DEC_BITS-1:0] r_hu;
    logic [dddw_pkg::DEC_BITS-1:0] r_te;

    logic [15:0] w_div;
    logic        w_ge;
    logic [15:0] w_diff;

    // One compare-subtract, reused for every quotient bit
    assign w_div  = dddw_pkg::f_divisor(r_step);
    assign w_ge   = (r_rem >= w_div);
    assign w_diff = r_rem - w_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 4'd1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_value;
            r_th  <= '0;
            r_hu  <= '0;
            r_te  <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= w_diff;
            end
            if (r_step <= TH_END) begin
                r_th <= {r_th[dddw_pkg::TH_BITS-2:0], w_ge};
            end else if (r_step <= HU_END) begin
                r_hu <= {r_hu[dddw_pkg::DEC_BITS-2:0], w_ge};
            end else begin
                r_te <= {r_te[dddw_pkg::DEC_BITS-2:0], w_ge};
            end
        end
    end

    assign o_res.done      = r_done;
    assign o_res.thousands = r_th;
    assign o_res.hundreds  = r_hu;
    assign o_res.tens      = r_te;
    assign o_res.ones      = r_rem[dddw_pkg::DEC_BITS-1:0];

endmodule
